### src/ascii_radix_converter_defines.svh
`ifndef ASCII_RADIX_CONVERTER_DEFINES_SVH
`define ASCII_RADIX_CONVERTER_DEFINES_SVH

// check a consequent in the same cycle as its antecedent
`define ARC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// check a consequent in the cycle after its antecedent
`define ARC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

// check what a reset cycle leaves behind
`define ARC_ASSERT_RESET(label, cons, msg) \
  label: assert property (@(posedge clk) rst |=> (cons)) else $error(msg);

`endif

### src/arc_pkg.sv
`default_nettype none

package arc_pkg;

  localparam logic [3:0] OP_B2O = 4'd0;
  localparam logic [3:0] OP_B2D = 4'd1;
  localparam logic [3:0] OP_B2H = 4'd2;
  localparam logic [3:0] OP_O2B = 4'd3;
  localparam logic [3:0] OP_O2D = 4'd4;
  localparam logic [3:0] OP_O2H = 4'd5;
  localparam logic [3:0] OP_H2B = 4'd6;
  localparam logic [3:0] OP_H2O = 4'd7;
  localparam logic [3:0] OP_H2D = 4'd8;
  localparam logic [3:0] OP_MAX = OP_H2D;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_BAD_DIGIT = 2'd1;
  localparam logic [1:0] ST_OVERFLOW  = 2'd2;

  localparam logic [7:0] CHAR_ZERO        = 8'h30;
  localparam logic [7:0] CHAR_NINE        = 8'h39;
  localparam logic [7:0] CHAR_UP_A        = 8'h41;
  localparam logic [7:0] CHAR_UP_F        = 8'h46;
  localparam logic [7:0] CHAR_LO_A        = 8'h61;
  localparam logic [7:0] CHAR_LO_F        = 8'h66;
  localparam logic [7:0] CHAR_X           = 8'h78;
  localparam logic [7:0] HEX_UPPER_OFFSET = 8'd55;
  localparam logic [7:0] HEX_LOWER_OFFSET = 8'd87;
  localparam logic [4:0] BAD_DIGIT        = 5'd16;

  typedef enum logic [3:0] {
    S_IDLE,
    S_PROC,
    S_EXPAND,
    S_LOAD,
    S_DABBLE,
    S_SKIP,
    S_PREFIX_ZERO,
    S_PREFIX_X,
    S_DIGITS
  } state_t;

  typedef enum logic [1:0] {
    FMT_OCT,
    FMT_DEC,
    FMT_HEX
  } fmt_t;

  typedef struct packed {
    logic load;
    fmt_t fmt;
    logic dabble;
    logic dabble_bit;
    logic shift;
  } dig_cmd_t;

  typedef struct packed {
    logic       final_res;
    logic [1:0] status;
    logic [7:0] out_char;
  } res_t;

  function automatic logic [4:0] digit_of(input logic [7:0] sym);
    logic [4:0] d;
    if (sym >= CHAR_ZERO && sym <= CHAR_NINE) begin
      d = 5'(sym - CHAR_ZERO);
    end else if (sym >= CHAR_UP_A && sym <= CHAR_UP_F) begin
      d = 5'(sym - HEX_UPPER_OFFSET);
    end else if (sym >= CHAR_LO_A && sym <= CHAR_LO_F) begin
      d = 5'(sym - HEX_LOWER_OFFSET);
    end else begin
      d = BAD_DIGIT;
    end
    return d;
  endfunction

  function automatic logic [7:0] digit_char(input logic [3:0] d);
    logic [7:0] c;
    if (d < 4'd10) begin
      c = CHAR_ZERO + 8'(d);
    end else begin
      c = HEX_LOWER_OFFSET + 8'(d);
    end
    return c;
  endfunction

  function automatic logic [2:0] radix_bits(input logic [3:0] mode);
    logic [2:0] w;
    case (mode) inside
      OP_B2O, OP_B2D, OP_B2H: w = 3'd1;
      OP_O2B, OP_O2D, OP_O2H: w = 3'd3;
      default:                w = 3'd4;
    endcase
    return w;
  endfunction

  function automatic fmt_t fmt_of(input logic [3:0] mode);
    fmt_t f;
    case (mode) inside
      OP_B2O, OP_H2O: f = FMT_OCT;
      OP_B2H, OP_O2H: f = FMT_HEX;
      default:        f = FMT_DEC;
    endcase
    return f;
  endfunction

endpackage

`default_nettype wire

### src/arc_digit_shifter.sv
`default_nettype none

module arc_digit_shifter #(
  parameter int VALUE_BITS = 32
) (
  input  logic                   clk,
  input  arc_pkg::dig_cmd_t      cmd,
  input  logic [VALUE_BITS-1:0]  acc,
  output logic [3:0]             top_digit
);

  localparam int DIGS  = (VALUE_BITS + 2) / 3;
  localparam int OCT_W = 3 * DIGS;
  localparam int REG_W = 4 * DIGS;

  logic [REG_W-1:0] digits;
  logic [REG_W-1:0] digits_next;
  logic [REG_W-1:0] oct_val;
  logic [REG_W-1:0] adj;
  logic [OCT_W-1:0] acc_oct;

  assign acc_oct   = OCT_W'(acc);
  assign top_digit = digits[REG_W-1 -: 4];

  always_comb begin
    for (int i = 0; i < DIGS; i++) begin
      oct_val[4*i +: 4] = {1'b0, acc_oct[3*i +: 3]};
      adj[4*i +: 4] = (digits[4*i +: 4] >= 4'd5) ? digits[4*i +: 4] + 4'd3
                                                 : digits[4*i +: 4];
    end
  end

  always_comb begin
    digits_next = digits;
    if (cmd.load) begin
      unique case (cmd.fmt)
        arc_pkg::FMT_OCT: digits_next = oct_val;
        arc_pkg::FMT_HEX: digits_next = REG_W'(acc);
        default:          digits_next = '0;
      endcase
    end else if (cmd.dabble) begin
      digits_next = {adj[REG_W-2:0], cmd.dabble_bit};
    end else if (cmd.shift) begin
      digits_next = {digits[REG_W-5:0], 4'd0};
    end
  end

  always_ff @(posedge clk) begin
    digits <= digits_next;
  end

endmodule

`default_nettype wire

### src/arc_ctrl.sv
`default_nettype none

module arc_ctrl #(
  parameter int VALUE_BITS = 32
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [7:0]            s_tdata,
  input  logic [3:0]            s_tuser,
  input  logic                  s_tlast,
  output logic                  res_valid,
  input  logic                  res_ready,
  output arc_pkg::res_t         res,
  output arc_pkg::dig_cmd_t     cmd,
  output logic [VALUE_BITS-1:0] acc,
  input  logic [3:0]            top_digit
);

  localparam int DIGS  = (VALUE_BITS + 2) / 3;
  localparam int REM_W = $clog2(DIGS + 1);
  localparam int DAB_W = $clog2(VALUE_BITS + 1);

  arc_pkg::state_t state;
  arc_pkg::state_t state_next;

  logic [3:0]       mode;
  logic             ovf;
  logic             failed;
  logic             mid;
  logic [3:0]       in_op;
  logic [7:0]       in_sym;
  logic             in_last;
  logic [1:0]       bit_idx;
  logic [REM_W-1:0] rem;
  logic [DAB_W-1:0] dab_cnt;

  logic                  first;
  logic [3:0]            mode_eff;
  logic [VALUE_BITS-1:0] acc_eff;
  logic                  ovf_eff;
  logic                  failed_eff;
  logic                  err_op;
  logic [4:0]            digit;
  logic [3:0]            dval;
  logic [2:0]            shamt;
  logic [1:0]            first_idx;
  logic                  bad;
  logic                  expand;
  logic                  ovf_top;
  logic                  ovf_new;
  logic [VALUE_BITS-1:0] acc_new;
  logic                  accum_ok;
  logic                  need_out;
  logic                  commit;
  logic                  skip;
  arc_pkg::fmt_t         fmt;
  logic [REM_W-1:0]      rem_min;

  assign first      = !mid;
  assign mode_eff   = first ? in_op : mode;
  assign acc_eff    = first ? '0 : acc;
  assign ovf_eff    = first ? 1'b0 : ovf;
  assign err_op     = first && (in_op > arc_pkg::OP_MAX);
  assign failed_eff = first ? err_op : failed;
  assign digit      = arc_pkg::digit_of(in_sym);
  assign dval       = digit[3:0];
  assign shamt      = arc_pkg::radix_bits(mode_eff);
  assign first_idx  = 2'(shamt - 3'd1);
  assign bad        = !failed_eff && (digit >= (5'd1 << shamt));
  assign expand     = (mode_eff == arc_pkg::OP_O2B) || (mode_eff == arc_pkg::OP_H2B);
  assign accum_ok   = !failed_eff && !bad && !expand;

  always_comb begin
    case (shamt)
      3'd1:    ovf_top = acc_eff[VALUE_BITS-1];
      3'd3:    ovf_top = |acc_eff[VALUE_BITS-1 -: 3];
      default: ovf_top = |acc_eff[VALUE_BITS-1 -: 4];
    endcase
  end

  assign ovf_new  = ovf_eff || ovf_top;
  assign acc_new  = (acc_eff << shamt) | VALUE_BITS'(dval);
  assign need_out = err_op || bad || (!failed_eff && expand) || (accum_ok && in_last && ovf_new);

  assign fmt     = arc_pkg::fmt_of(mode);
  assign rem_min = (fmt == arc_pkg::FMT_HEX) ? REM_W'(2) : REM_W'(1);
  assign skip    = (rem > rem_min) && (top_digit == 4'd0);

  always_comb begin
    state_next = state;
    unique case (state)
      arc_pkg::S_IDLE: begin
        if (s_tvalid) state_next = arc_pkg::S_PROC;
      end
      arc_pkg::S_PROC: begin
        if (commit) begin
          if (failed_eff || bad) begin
            state_next = arc_pkg::S_IDLE;
          end else if (expand) begin
            state_next = arc_pkg::S_EXPAND;
          end else if (in_last && !ovf_new) begin
            state_next = arc_pkg::S_LOAD;
          end else begin
            state_next = arc_pkg::S_IDLE;
          end
        end
      end
      arc_pkg::S_EXPAND: begin
        if (res_ready && bit_idx == 2'd0) state_next = arc_pkg::S_IDLE;
      end
      arc_pkg::S_LOAD: begin
        state_next = (fmt == arc_pkg::FMT_DEC) ? arc_pkg::S_DABBLE : arc_pkg::S_SKIP;
      end
      arc_pkg::S_DABBLE: begin
        if (dab_cnt == DAB_W'(1)) state_next = arc_pkg::S_SKIP;
      end
      arc_pkg::S_SKIP: begin
        if (!skip) begin
          state_next = (fmt == arc_pkg::FMT_HEX) ? arc_pkg::S_PREFIX_ZERO : arc_pkg::S_DIGITS;
        end
      end
      arc_pkg::S_PREFIX_ZERO: begin
        if (res_ready) state_next = arc_pkg::S_PREFIX_X;
      end
      arc_pkg::S_PREFIX_X: begin
        if (res_ready) state_next = arc_pkg::S_DIGITS;
      end
      arc_pkg::S_DIGITS: begin
        if (res_ready && rem == REM_W'(1)) state_next = arc_pkg::S_IDLE;
      end
      default: state_next = arc_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    s_tready  = 1'b0;
    res_valid = 1'b0;
    res       = '0;
    cmd       = '0;
    commit    = 1'b0;
    unique case (state)
      arc_pkg::S_IDLE: begin
        s_tready = 1'b1;
      end
      arc_pkg::S_PROC: begin
        res_valid = need_out;
        commit    = !need_out || res_ready;
        if (err_op || bad) begin
          res.status    = arc_pkg::ST_BAD_DIGIT;
          res.final_res = 1'b1;
        end else if (expand) begin
          res.out_char = arc_pkg::CHAR_ZERO | 8'(dval[first_idx]);
        end else begin
          res.status    = arc_pkg::ST_OVERFLOW;
          res.final_res = 1'b1;
        end
      end
      arc_pkg::S_EXPAND: begin
        res_valid     = 1'b1;
        res.out_char  = arc_pkg::CHAR_ZERO | 8'(dval[bit_idx]);
        res.final_res = in_last && (bit_idx == 2'd0);
      end
      arc_pkg::S_LOAD: begin
        cmd.load = 1'b1;
        cmd.fmt  = fmt;
      end
      arc_pkg::S_DABBLE: begin
        cmd.dabble     = 1'b1;
        cmd.dabble_bit = acc[VALUE_BITS-1];
      end
      arc_pkg::S_SKIP: begin
        cmd.shift = skip;
      end
      arc_pkg::S_PREFIX_ZERO: begin
        res_valid    = 1'b1;
        res.out_char = arc_pkg::CHAR_ZERO;
      end
      arc_pkg::S_PREFIX_X: begin
        res_valid    = 1'b1;
        res.out_char = arc_pkg::CHAR_X;
      end
      arc_pkg::S_DIGITS: begin
        res_valid     = 1'b1;
        res.out_char  = arc_pkg::digit_char(top_digit);
        res.final_res = (rem == REM_W'(1));
        cmd.shift     = res_ready;
      end
      default: begin
        s_tready = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_op   <= s_tuser;
      in_sym  <= s_tdata;
      in_last <= s_tlast;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= arc_pkg::S_IDLE;
      mode    <= '0;
      acc     <= '0;
      ovf     <= 1'b0;
      failed  <= 1'b0;
      mid     <= 1'b0;
      bit_idx <= '0;
      rem     <= '0;
      dab_cnt <= '0;
    end else begin
      state <= state_next;
      if (state == arc_pkg::S_PROC && commit) begin
        mode    <= mode_eff;
        mid     <= !in_last;
        failed  <= failed_eff || bad;
        acc     <= accum_ok ? acc_new : acc_eff;
        ovf     <= accum_ok ? ovf_new : ovf_eff;
        bit_idx <= first_idx - 2'd1;
      end
      if (state == arc_pkg::S_EXPAND && res_ready) begin
        bit_idx <= bit_idx - 2'd1;
      end
      if (state == arc_pkg::S_LOAD) begin
        rem     <= REM_W'(DIGS);
        dab_cnt <= DAB_W'(VALUE_BITS);
      end
      if (state == arc_pkg::S_DABBLE) begin
        acc     <= acc << 1;
        dab_cnt <= dab_cnt - DAB_W'(1);
      end
      if ((state == arc_pkg::S_SKIP && skip) || (state == arc_pkg::S_DIGITS && res_ready)) begin
        rem <= rem - REM_W'(1);
      end
    end
  end

endmodule

`default_nettype wire

### src/ascii_radix_converter.sv
// Accepts one character per transaction when idle; a character that gives no result passes through PROC back to IDLE.
// Expansion modes give 3 or 4 results, one per cycle while the output side takes them.
// Last character of an accumulating mode without overflow: a load state, shift-add steps for decimal,
// a scan that drops leading zeros, then one result per cycle while the output side takes them.
// Each result leaves through an output register.
// rst is synchronous, active high: clears the sequencer, the string state and the output valid.
`default_nettype none

module ascii_radix_converter #(
  parameter int VALUE_BITS = 32
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // symbol
  input  logic [3:0] s_tuser,   // opcode
  input  logic       s_tlast,
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,   // out_char
  output logic [1:0] m_tuser,   // status
  output logic       m_tlast
);

  logic                  res_valid;
  logic                  res_ready;
  arc_pkg::res_t         res;
  arc_pkg::dig_cmd_t     cmd;
  logic [VALUE_BITS-1:0] acc;
  logic [3:0]            top_digit;

  arc_ctrl #(
    .VALUE_BITS(VALUE_BITS)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .s_tlast   (s_tlast),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res),
    .cmd       (cmd),
    .acc       (acc),
    .top_digit (top_digit)
  );

  arc_digit_shifter #(
    .VALUE_BITS(VALUE_BITS)
  ) u_shifter (
    .clk       (clk),
    .cmd       (cmd),
    .acc       (acc),
    .top_digit (top_digit)
  );

  assign res_ready = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_ready) begin
      m_tvalid <= res_valid;
    end
  end

  // hold payload while the output stalls
  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      m_tdata <= res.out_char;
      m_tuser <= res.status;
      m_tlast <= res.final_res;
    end
  end

endmodule

`default_nettype wire

### src/arc_checker.sv
`default_nettype none
`include "ascii_radix_converter_defines.svh"

module arc_checker (
  input logic       clk,
  input logic       rst,
  input logic       m_tvalid,
  input logic       m_tready,
  input logic [7:0] m_tdata,
  input logic [1:0] m_tuser,
  input logic       m_tlast
);

  `ARC_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast), "stalled result transaction changed")

  `ARC_ASSERT_NOW(a_err_form, m_tvalid && m_tuser != arc_pkg::ST_OK, m_tdata == 8'd0 && m_tlast && (m_tuser == arc_pkg::ST_BAD_DIGIT || m_tuser == arc_pkg::ST_OVERFLOW), "malformed error result")

  `ARC_ASSERT_NOW(a_char_set, m_tvalid && m_tuser == arc_pkg::ST_OK, (m_tdata >= arc_pkg::CHAR_ZERO && m_tdata <= arc_pkg::CHAR_NINE) || (m_tdata >= arc_pkg::CHAR_LO_A && m_tdata <= arc_pkg::CHAR_LO_F) || m_tdata == arc_pkg::CHAR_X, "result character outside digit set")

  `ARC_ASSERT_RESET(a_reset_empty, !m_tvalid, "output valid after reset")

endmodule

bind ascii_radix_converter arc_checker u_arc_checker (.*);

`default_nettype wire

### verif/ascii_radix_converter_test.sv
`timescale 1ns / 1ps

module ascii_radix_converter_test;

  localparam int VALUE_BITS = 32;
  localparam logic [63:0] VALUE_MASK = {64{1'b1}} >> (64 - VALUE_BITS);
  localparam logic [3:0] OP_UNKNOWN_TOP = 4'hF;
  localparam int LIMIT_CYCLES = 400000;
  localparam int HOLD_CYCLES = 400;
  localparam int TAIL_CYCLES = 100;
  localparam int RANDOM_ITEMS = 350;

  class radix_scoreboard;
    logic [3:0] mode_now;
    logic [63:0] value_acc;
    bit wrapped;
    bit rejected;
    bit in_string;
    arc_pkg::res_t awaited_chars[$];
    int errors;
    int accepted;
    int strings;
    int chars_checked;
    int error_results;

    function int src_radix(logic [3:0] m);
      if (m <= arc_pkg::OP_B2H) return 2;
      if (m <= arc_pkg::OP_O2H) return 8;
      return 16;
    endfunction

    function int dst_radix(logic [3:0] m);
      if (m == arc_pkg::OP_B2O || m == arc_pkg::OP_H2O) return 8;
      if (m == arc_pkg::OP_B2H || m == arc_pkg::OP_O2H) return 16;
      return 10;
    endfunction

    function int digit_val(logic [7:0] c);
      if (c >= arc_pkg::CHAR_ZERO && c <= arc_pkg::CHAR_NINE) return int'(c - arc_pkg::CHAR_ZERO);
      if (c >= arc_pkg::CHAR_UP_A && c <= arc_pkg::CHAR_UP_F) return int'(c - arc_pkg::CHAR_UP_A) + 10;
      if (c >= arc_pkg::CHAR_LO_A && c <= arc_pkg::CHAR_LO_F) return int'(c - arc_pkg::CHAR_LO_A) + 10;
      return int'(arc_pkg::BAD_DIGIT);
    endfunction

    function void push(logic [7:0] ch, logic [1:0] st, logic fin);
      arc_pkg::res_t r;
      r.out_char = ch;
      r.status = st;
      r.final_res = fin;
      awaited_chars.push_back(r);
      if (st != arc_pkg::ST_OK) error_results++;
    endfunction

    function void emit_value(logic [63:0] value, int radix);
      int digs[$];
      logic [63:0] v;
      int k;
      v = value;
      do begin
        digs.push_back(int'(v % 64'(radix)));
        v = v / 64'(radix);
      end while (v != 0);
      if (radix == 16) begin
        while (digs.size() < 2) digs.push_back(0);
        push(arc_pkg::CHAR_ZERO, arc_pkg::ST_OK, 1'b0);
        push(arc_pkg::CHAR_X, arc_pkg::ST_OK, 1'b0);
      end
      for (k = digs.size() - 1; k >= 0; k--) begin
        if (digs[k] < 10) push(arc_pkg::CHAR_ZERO + 8'(digs[k]), arc_pkg::ST_OK, k == 0);
        else push(arc_pkg::CHAR_LO_A + 8'(digs[k] - 10), arc_pkg::ST_OK, k == 0);
      end
    endfunction

    // returns 0 for a character the block skips after an earlier rejection in its string
    function bit convert_char(logic [3:0] op, logic [7:0] sym, logic last);
      int base;
      int d;
      int k;
      bit counted;
      accepted++;
      counted = 1;
      if (!in_string) begin
        mode_now = op;
        value_acc = '0;
        wrapped = 0;
        rejected = 0;
        in_string = 1;
        strings++;
        if (op > arc_pkg::OP_MAX) begin
          rejected = 1;
          push(8'h00, arc_pkg::ST_BAD_DIGIT, 1'b1);
        end
      end else if (rejected) begin
        counted = 0;
      end
      if (!rejected) begin
        base = src_radix(mode_now);
        d = digit_val(sym);
        if (d >= base) begin
          rejected = 1;
          push(8'h00, arc_pkg::ST_BAD_DIGIT, 1'b1);
        end else if (mode_now == arc_pkg::OP_O2B || mode_now == arc_pkg::OP_H2B) begin
          for (k = (mode_now == arc_pkg::OP_O2B) ? 2 : 3; k >= 0; k--) begin
            push(arc_pkg::CHAR_ZERO + 8'((d >> k) & 1), arc_pkg::ST_OK, last && k == 0);
          end
        end else begin
          if (value_acc > (VALUE_MASK - 64'(d)) / 64'(base)) wrapped = 1;
          value_acc = (value_acc * 64'(base) + 64'(d)) & VALUE_MASK;
          if (last) begin
            if (wrapped) push(8'h00, arc_pkg::ST_OVERFLOW, 1'b1);
            else emit_value(value_acc, dst_radix(mode_now));
          end
        end
      end
      if (last) in_string = 0;
      return counted;
    endfunction

    function void check_char(logic [7:0] ch, logic [1:0] st, logic fin);
      arc_pkg::res_t want;
      chars_checked++;
      if (awaited_chars.size() == 0) begin
        $error("unexpected transaction: out_char %h status %0d final_res %0d", ch, st, fin);
        errors++;
        return;
      end
      want = awaited_chars.pop_front();
      if (ch !== want.out_char) begin
        $error("out_char: expected %h, actual %h", want.out_char, ch);
        errors++;
      end
      if (st !== want.status) begin
        $error("status: expected %0d, actual %0d", want.status, st);
        errors++;
      end
      if (fin !== want.final_res) begin
        $error("final_res: expected %0d, actual %0d", want.final_res, fin);
        errors++;
      end
    endfunction

    function int pending();
      return awaited_chars.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [7:0] s_tdata = '0;
  logic [3:0] s_tuser = '0;
  logic s_tlast = 1'b0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [7:0] m_tdata;
  logic [1:0] m_tuser;
  logic m_tlast;

  radix_scoreboard sb = new;
  logic [7:0] symbol_q[$];
  bit steady = 0;
  bit hold_done = 0;
  int hold_left = 0;
  int counted_items = 0;
  int cycle_count = 0;

  ascii_radix_converter #(.VALUE_BITS(VALUE_BITS)) dut (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tuser(s_tuser),
    .s_tlast(s_tlast),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .m_tuser(m_tuser),
    .m_tlast(m_tlast)
  );

  always #4 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("timed out after %0d cycles", cycle_count);
      $display("status: fail");
      $finish;
    end
  end

  // receive side: check, then pick the next ready
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) sb.check_char(m_tdata, m_tuser, m_tlast);
    if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      m_tready <= 1'b0;
    end else if (!hold_done && sb.accepted >= 80) begin
      hold_done <= 1;
      hold_left <= HOLD_CYCLES;
      m_tready <= 1'b0;
    end else begin
      m_tready <= steady || ($urandom_range(0, 99) >= 29);
    end
  end

  task automatic send_symbol(logic [3:0] op, logic [7:0] sym, logic last);
    int gap;
    gap = 0;
    if (!steady) while ($urandom_range(0, 99) < 29) gap++;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= op;
    s_tdata <= sym;
    s_tlast <= last;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    if (sb.convert_char(op, sym, last)) counted_items++;
  endtask

  // opcode matters on the first character only; randomize it elsewhere
  task automatic send_queue(logic [3:0] op);
    int k;
    logic [3:0] tag;
    for (k = 0; k < symbol_q.size(); k++) begin
      tag = (k == 0) ? op : 4'($urandom_range(0, 15));
      send_symbol(tag, symbol_q[k], k == symbol_q.size() - 1);
    end
    symbol_q.delete();
  endtask

  task automatic send_text(logic [3:0] op, string txt);
    int k;
    for (k = 0; k < txt.len(); k++) symbol_q.push_back(txt[k]);
    send_queue(op);
  endtask

  function automatic logic [7:0] digit_text(int d);
    if (d < 10) return arc_pkg::CHAR_ZERO + 8'(d);
    if ($urandom_range(0, 1) == 1) return arc_pkg::CHAR_UP_A + 8'(d - 10);
    return arc_pkg::CHAR_LO_A + 8'(d - 10);
  endfunction

  task automatic send_random_string();
    logic [3:0] op;
    int radix;
    int len;
    int roll;
    int k;
    bit all_max;
    if ($urandom_range(0, 99) < 8) begin
      op = 4'($urandom_range(int'(arc_pkg::OP_MAX) + 1, int'(OP_UNKNOWN_TOP)));
    end else begin
      op = 4'($urandom_range(int'(arc_pkg::OP_B2O), int'(arc_pkg::OP_MAX)));
    end
    radix = (op <= arc_pkg::OP_B2H) ? 2 : (op <= arc_pkg::OP_O2H) ? 8 : 16;
    roll = $urandom_range(0, 99);
    if (roll < 12) begin
      len = (radix == 2) ? $urandom_range(30, 35) :
            (radix == 8) ? $urandom_range(10, 12) : $urandom_range(7, 9);
    end else begin
      len = $urandom_range(1, 6);
    end
    all_max = ($urandom_range(0, 9) == 0);
    for (k = 0; k < len; k++) begin
      if ($urandom_range(0, 99) < 6) symbol_q.push_back(8'($urandom_range(0, 255)));
      else if (all_max) symbol_q.push_back(digit_text(radix - 1));
      else symbol_q.push_back(digit_text($urandom_range(0, radix - 1)));
    end
    send_queue(op);
  endtask

  initial begin
    bit paused;
    paused = 0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    send_text(arc_pkg::OP_B2O, "1");
    send_text(arc_pkg::OP_B2D, "0");
    send_text(arc_pkg::OP_B2H, "101");
    send_text(arc_pkg::OP_O2B, "07");
    send_text(arc_pkg::OP_O2D, "81");
    send_text(arc_pkg::OP_O2H, "0");
    send_text(arc_pkg::OP_H2B, "aF");
    send_text(OP_UNKNOWN_TOP, "12");
    send_text(arc_pkg::OP_H2O, "Ff");
    send_text(arc_pkg::OP_H2D, "1ffffffff");

    counted_items = 0;
    while (counted_items < RANDOM_ITEMS) begin
      steady <= (counted_items >= 200 && counted_items < 260);
      if (!paused && counted_items >= 150) begin
        paused = 1;
        s_tvalid <= 1'b0;
        do @(posedge clk); while (sb.pending() > 0);
      end
      send_random_string();
    end
    s_tvalid <= 1'b0;
    steady <= 0;

    do @(posedge clk); while (sb.pending() > 0);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("covered %0d strings, %0d characters in, %0d characters out",
             sb.strings, sb.accepted, sb.chars_checked);
    $display("  all nine conversions, unknown opcodes, bad digits and overflow: %0d error results",
             sb.error_results);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
